@@ hdl/tlv8d_pkg.sv @@
// Shared types and constants for the TLV8 stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlv8d_pkg;

	localparam int MAX_ITEMS_DEF = 16;

	localparam logic [7:0]  FRAG_MAX       = 8'hFF;
	localparam logic [7:0]  PRIOR_TYPE_RST = 8'hFF;
	localparam logic [15:0] LEN_CAP        = 16'hFFFF;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_LONG  = 2'd2;
	localparam logic [1:0] ERR_TRUNC = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  itype;
		logic [3:0]  index;
		logic [7:0]  data;
		logic [15:0] offset;
		logic [15:0] length;
		logic [1:0]  err;
		logic        last;
	} result_t;

	// control between input stage and result buffer
	typedef struct packed {
		logic [1:0] free;   // slots open after this cycle's pop
	} buf_status_t;

	typedef struct packed {
		logic [1:0] count;  // results pushed this cycle
	} buf_push_t;

endpackage

`default_nettype wire

@@ hdl/tlv8d_core.sv @@
// Per-byte TLV8 parser: fragment state, item merging and result generation.
// Depends on tlv8d_pkg. State advances only when step is high.
`default_nettype none

module tlv8d_core import tlv8d_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_in,
	input  wire logic       eos_in,
	output logic [1:0]      res_count,
	output result_t         res0,
	output result_t         res1
);

	localparam int IW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_LEN  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	phase_t      phase_q, phase_m;
	logic [7:0]  ftype_q, ftype_m;
	logic [7:0]  frem_q, frem_m;
	logic [7:0]  ptype_q, ptype_m;
	logic [7:0]  plen_q, plen_m;
	logic [IW-1:0] items_q, items_m;
	logic        open_q, open_m;
	logic [15:0] mlen_q, mlen_m;

	logic        trunc;
	logic        merge;
	logic [1:0]  n;
	result_t     r [2];
	result_t     rx;
	logic [3:0]  idx_cur, idx_last, idx_last_m;

	assign idx_cur    = 4'(items_q - IW'(1));
	assign idx_last   = (items_q != '0) ? idx_cur : 4'd0;
	assign idx_last_m = (items_m != '0) ? 4'(items_m - IW'(1)) : 4'd0;
	assign merge      = open_q && (byte_in == ptype_q) && (plen_q == FRAG_MAX);

	always_comb begin
		phase_m = phase_q;
		ftype_m = ftype_q;
		frem_m  = frem_q;
		ptype_m = ptype_q;
		plen_m  = plen_q;
		items_m = items_q;
		open_m  = open_q;
		mlen_m  = mlen_q;
		trunc   = 1'b0;
		n       = 2'd0;
		r[0]    = '0;
		r[1]    = '0;
		rx      = '0;

		unique case (phase_q)
			PH_LEN: begin
				ptype_m = ftype_q;
				plen_m  = byte_in;
				frem_m  = byte_in;
				phase_m = (byte_in != 8'd0) ? PH_DATA : PH_TYPE;
				trunc   = eos_in && (byte_in != 8'd0);
			end
			PH_DATA: begin
				if (open_q) begin
					rx = '0;
					rx.itype = ftype_q;
					if (mlen_q < LEN_CAP) begin
						rx.kind   = KIND_DATA;
						rx.index  = idx_cur;
						rx.data   = byte_in;
						rx.offset = mlen_q;
						mlen_m    = mlen_q + 16'd1;
					end else begin
						rx.kind  = KIND_ERR;
						rx.index = idx_last;
						rx.err   = ERR_LONG;
					end
					r[0] = rx;
					n    = 2'd1;
				end
				if (frem_q != 8'd0)
					frem_m = frem_q - 8'd1;
				if (frem_m == 8'd0)
					phase_m = PH_TYPE;
				else if (eos_in)
					trunc = 1'b1;
			end
			default: begin
				// type byte; unused phase code lands here too
				ftype_m = byte_in;
				phase_m = PH_LEN;
				trunc   = eos_in;
				if (!merge) begin
					if (open_q) begin
						rx = '0;
						rx.kind   = KIND_DONE;
						rx.itype  = ftype_q;
						rx.index  = idx_cur;
						rx.length = mlen_q;
						r[0] = rx;
						n    = 2'd1;
					end
					open_m = 1'b0;
					if (!eos_in) begin
						if (items_q >= IW'(MAX_ITEMS)) begin
							rx = '0;
							rx.kind  = KIND_ERR;
							rx.itype = byte_in;
							rx.index = idx_last;
							rx.err   = ERR_FULL;
							r[n[0]] = rx;
							n = n + 2'd1;
						end else begin
							items_m = items_q + IW'(1);
							open_m  = 1'b1;
							mlen_m  = 16'd0;
						end
					end
				end
			end
		endcase

		if (eos_in) begin
			rx = '0;
			rx.itype = ftype_m;
			if (trunc) begin
				rx.kind  = KIND_ERR;
				rx.index = idx_last_m;
				rx.err   = ERR_TRUNC;
				r[n[0]] = rx;
				n = n + 2'd1;
			end else if (open_m) begin
				rx.kind   = KIND_DONE;
				rx.index  = 4'(items_m - IW'(1));
				rx.length = mlen_m;
				r[n[0]] = rx;
				n = n + 2'd1;
			end
		end

		if (n == 2'd2)
			r[1].last = 1'b1;
		else if (n == 2'd1)
			r[0].last = 1'b1;
	end

	assign res_count = n;
	assign res0      = r[0];
	assign res1      = r[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			ftype_q <= 8'd0;
			frem_q  <= 8'd0;
			ptype_q <= PRIOR_TYPE_RST;
			plen_q  <= 8'd0;
			items_q <= '0;
			open_q  <= 1'b0;
			mlen_q  <= 16'd0;
		end else if (step) begin
			if (eos_in) begin
				// stream over: back to the start state
				phase_q <= PH_TYPE;
				ftype_q <= 8'd0;
				frem_q  <= 8'd0;
				ptype_q <= PRIOR_TYPE_RST;
				plen_q  <= 8'd0;
				items_q <= '0;
				open_q  <= 1'b0;
				mlen_q  <= 16'd0;
			end else begin
				phase_q <= phase_m;
				ftype_q <= ftype_m;
				frem_q  <= frem_m;
				ptype_q <= ptype_m;
				plen_q  <= plen_m;
				items_q <= items_m;
				open_q  <= open_m;
				mlen_q  <= mlen_m;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/tlv8d_outbuf.sv @@
// Two-entry result buffer: takes up to two results per cycle, hands out one.
// Depends on tlv8d_pkg.
`default_nettype none

module tlv8d_outbuf import tlv8d_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  buf_push_t push,
	input  result_t   push0,
	input  result_t   push1,
	input  wire logic pop,
	output buf_status_t status,
	output logic      head_valid,
	output result_t   head
);

	result_t    slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic [1:0] kept;
	result_t    rem0;

	assign kept        = cnt_q - {1'b0, pop};
	assign rem0        = (pop) ? slot1_q : slot0_q;
	assign status.free = 2'd2 - kept;
	assign head_valid  = (cnt_q != 2'd0);
	assign head        = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= kept + push.count;
	end

	// both slots held when full and not popped
	always_ff @(posedge clk) begin
		if (kept == 2'd0) begin
			slot0_q <= push0;
			slot1_q <= push1;
		end else if (kept == 2'd1) begin
			slot0_q <= rem0;
			slot1_q <= push0;
		end
	end

endmodule

`default_nettype wire

@@ hdl/tlv8_stream_decoder.sv @@
// TLV8 stream decoder top level: input register, parser core, result buffer.
// Depends on tlv8d_pkg, tlv8d_core, tlv8d_outbuf.
//
// Usage:
//  Input channel (item_valid/item_ready) takes one stream byte per request,
//  with end_of_stream set on the final byte. Result channel
//  (result_valid/result_ready) returns data bytes with type, item index and
//  offset, item-complete records with merged length, and error records.
//  last_of_run marks the final result caused by one input byte.
//  An accepted byte is held in the input register, and its results are written to the result buffer.
//  Throughput: one byte per cycle; the parser takes a byte once the
//  two-entry result buffer has room for all of its results (zero to two),
//  so the results of a byte with two are handed out one after the other.
//  A stalled receiver fills the result buffer, then the input register,
//  then item_ready drops; nothing is lost.
//  Reset clears the parser to expect a type byte and empties both stages.
//  After a byte with end_of_stream the parser returns to that same state.
`default_nettype none

module tlv8_stream_decoder import tlv8d_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  stream_byte,
	input  wire logic        end_of_stream,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       item_type,
	output logic [3:0]       item_index,
	output logic [7:0]       data_value,
	output logic [15:0]      byte_offset,
	output logic [15:0]      item_length,
	output logic [1:0]       error_code,
	output logic             last_of_run
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        advance;
	logic [1:0]  nres;
	result_t     res0, res1, head;
	buf_status_t bstat;
	buf_push_t   bpush;

	assign advance     = v_s1 && (nres <= bstat.free);
	assign item_ready  = !v_s1 || advance;
	assign bpush.count = advance ? nres : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (item_valid && item_ready)
			v_s1 <= 1'b1;
		else if (advance)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			byte_s1 <= stream_byte;
			eos_s1  <= end_of_stream;
		end
	end

	tlv8d_core #(.MAX_ITEMS(MAX_ITEMS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.eos_in    (eos_s1),
		.res_count (nres),
		.res0      (res0),
		.res1      (res1)
	);

	tlv8d_outbuf u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (bpush),
		.push0      (res0),
		.push1      (res1),
		.pop        (result_valid && result_ready),
		.status     (bstat),
		.head_valid (result_valid),
		.head       (head)
	);

	assign result_kind = head.kind;
	assign item_type   = head.itype;
	assign item_index  = head.index;
	assign data_value  = head.data;
	assign byte_offset = head.offset;
	assign item_length = head.length;
	assign error_code  = head.err;
	assign last_of_run = head.last;

endmodule

`default_nettype wire

@@ hdl/tlv8d_checker.sv @@
// Port-level checks for the TLV8 stream decoder, bound to the top level.
// Depends on tlv8d_pkg and tlv8_stream_decoder.
`default_nettype none

module tlv8d_checker import tlv8d_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_ready,
	input wire logic [1:0]  result_kind,
	input wire logic [7:0]  data_value,
	input wire logic [15:0] byte_offset,
	input wire logic [15:0] item_length,
	input wire logic [1:0]  error_code
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result request dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_kind == KIND_DATA || result_kind == KIND_DONE ||
			result_kind == KIND_ERR))
		else $error("bad result kind");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_DATA |->
			error_code == ERR_NONE && item_length == 16'd0)
		else $error("data result carries length or error");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_DONE |->
			error_code == ERR_NONE && data_value == 8'd0 && byte_offset == 16'd0)
		else $error("complete result carries stray fields");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_ERR |->
			error_code != ERR_NONE && item_length == 16'd0 && byte_offset == 16'd0)
		else $error("error result malformed");

endmodule

bind tlv8_stream_decoder tlv8d_checker u_tlv8d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_kind  (result_kind),
	.data_value   (data_value),
	.byte_offset  (byte_offset),
	.item_length  (item_length),
	.error_code   (error_code)
);

`default_nettype wire
